// ===== rtl/mcfr_pkg.sv =====
// Shared types, codes and reset values of the motor command frame receiver.
package mcfr_pkg;

  // Default sizes of the frame and of the motor set
  localparam int MOTOR_COUNT_DEF = 8;
  localparam int FRAME_BYTES_DEF = 10;

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] REG_SYNC_VALUE    = 2'd0;
  localparam logic [1:0] REG_FRAME_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_LIGHT_HOLD    = 2'd2;

  localparam logic [7:0]  SYNC_VALUE_RST    = 8'hAA;
  localparam logic [15:0] FRAME_TIMEOUT_RST = 16'd100;
  localparam logic [15:0] LIGHT_HOLD_RST    = 16'd500;

  // Result kinds
  localparam logic [1:0] EV_MOTOR      = 2'd0;
  localparam logic [1:0] EV_BAD_SUM    = 2'd1;
  localparam logic [1:0] EV_TIMEOUT    = 2'd2;
  localparam logic [1:0] EV_LIGHT_IDLE = 2'd3;

  // Status light codes
  localparam logic [1:0] LIGHT_IDLE  = 2'd0;
  localparam logic [1:0] LIGHT_GOOD  = 2'd1;
  localparam logic [1:0] LIGHT_ERROR = 2'd2;

  // Input actions
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [2:0] motor_number;
    logic [7:0] forward_level;
    logic [8:0] reverse_level;
    logic [1:0] light_code;
    logic       last_of_run;
  } out_word_t;

endpackage

// ===== rtl/mcfr_level_unit.sv =====
// Duty level unit: turns one signed motor byte into forward and reverse levels.
module mcfr_level_unit (
  input  logic [7:0] motor_byte,
  output logic [7:0] forward_level,
  output logic [8:0] reverse_level
);

  logic [7:0] magnitude;

  // 256 - b, which is 128 at most for a negative byte
  assign magnitude = 8'(9'd256 - {1'b0, motor_byte});

  always_comb begin
    forward_level = '0;
    reverse_level = '0;
    if (motor_byte[7]) begin
      reverse_level = {magnitude, 1'b0};
    end else begin
      forward_level = {motor_byte[6:0], 1'b0};
    end
  end

endmodule

// ===== rtl/motor_command_frame_receiver.sv =====
// Motor command frame receiver: takes bytes and ticks, finds sync, checks the
// XOR checksum and emits one level word per motor through a shared level unit.
//
// Each input word (a received byte or a time tick) gives at most one result
// word, except the checksum byte of a good frame. That byte starts a sequencer
// that walks the motor store through the single level unit, a store read state
// and then an emit state per motor, so the input stalls until the last motor
// word is emitted, longer if the output is stalled. The input also stalls
// while a finished result word waits in the output register. The frame
// timeout runs from the sync byte; the status light hold counts ticks only
// while no frame is being collected.
module motor_command_frame_receiver #(
  parameter int MOTOR_COUNT = mcfr_pkg::MOTOR_COUNT_DEF,
  parameter int FRAME_BYTES = mcfr_pkg::FRAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  mcfr_pkg::in_word_t              in_data,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output mcfr_pkg::out_word_t             out_data,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mcfr_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [mcfr_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [mcfr_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int BT_W = $clog2(FRAME_BYTES);
  localparam int MI_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // configuration registers
  logic [7:0]  sync_value_r;
  logic [15:0] frame_timeout_r;
  logic [15:0] light_hold_r;

  // control state
  logic [1:0]      state_r, state_nxt;
  logic            collecting_r, collecting_nxt;
  logic [BT_W-1:0] bytes_taken_r, bytes_taken_nxt;
  logic [15:0]     frame_elapsed_r, frame_elapsed_nxt;
  logic [7:0]      running_xor_r, running_xor_nxt;
  logic            light_active_r, light_active_nxt;
  logic [15:0]     light_remaining_r, light_remaining_nxt;
  logic [MI_W-1:0] motor_idx_r, motor_idx_nxt;

  // motor store
  logic [7:0]      motor_mem [MOTOR_COUNT];
  logic [7:0]      motor_rd_r;
  logic            mem_we;
  logic [BT_W-1:0] data_idx;

  // output register
  logic                out_valid_r;
  mcfr_pkg::out_word_t out_data_r;
  mcfr_pkg::out_word_t out_word;
  logic                out_load;
  logic                out_free;

  logic        in_acc;
  logic        cfg_wr;
  logic [15:0] elapsed_inc;
  logic [15:0] remaining_dec;
  logic        last_motor;
  logic [7:0]  lvl_fwd;
  logic [8:0]  lvl_rev;

  mcfr_level_unit u_level (
    .motor_byte    (motor_rd_r),
    .forward_level (lvl_fwd),
    .reverse_level (lvl_rev)
  );

  // ---------------------------------------------------------------------------
  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_value_r    <= mcfr_pkg::SYNC_VALUE_RST;
      frame_timeout_r <= mcfr_pkg::FRAME_TIMEOUT_RST;
      light_hold_r    <= mcfr_pkg::LIGHT_HOLD_RST;
    end else if (cfg_wr) begin
      case (paddr[mcfr_pkg::CFG_ADDR_W-1:2])
        mcfr_pkg::REG_SYNC_VALUE:    sync_value_r    <= pwdata[7:0];
        mcfr_pkg::REG_FRAME_TIMEOUT: frame_timeout_r <= pwdata[15:0];
        mcfr_pkg::REG_LIGHT_HOLD:    light_hold_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[mcfr_pkg::CFG_ADDR_W-1:2])
      mcfr_pkg::REG_SYNC_VALUE:    prdata = mcfr_pkg::CFG_DATA_W'(sync_value_r);
      mcfr_pkg::REG_FRAME_TIMEOUT: prdata = mcfr_pkg::CFG_DATA_W'(frame_timeout_r);
      mcfr_pkg::REG_LIGHT_HOLD:    prdata = mcfr_pkg::CFG_DATA_W'(light_hold_r);
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE) || !out_free;
  assign in_acc   = in_valid && !in_stall;

  assign elapsed_inc   = (frame_elapsed_r == 16'hFFFF) ? frame_elapsed_r
                                                       : frame_elapsed_r + 16'd1;
  assign remaining_dec = (light_remaining_r != 16'd0) ? light_remaining_r - 16'd1
                                                      : 16'd0;
  assign data_idx      = bytes_taken_r - BT_W'(1);
  assign last_motor    = (motor_idx_r == MI_W'(MOTOR_COUNT - 1));

  // ---------------------------------------------------------------------------
  // frame tracking and motor sequencer
  always_comb begin
    state_nxt           = state_r;
    collecting_nxt      = collecting_r;
    bytes_taken_nxt     = bytes_taken_r;
    frame_elapsed_nxt   = frame_elapsed_r;
    running_xor_nxt     = running_xor_r;
    light_active_nxt    = light_active_r;
    light_remaining_nxt = light_remaining_r;
    motor_idx_nxt       = motor_idx_r;
    mem_we              = 1'b0;
    out_load            = 1'b0;
    out_word            = '0;
    out_word.last_of_run = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.action == mcfr_pkg::ACT_TICK) begin
            if (collecting_r) begin
              frame_elapsed_nxt = elapsed_inc;
              if (elapsed_inc >= frame_timeout_r) begin
                collecting_nxt      = 1'b0;
                light_active_nxt    = 1'b1;
                light_remaining_nxt = light_hold_r;
                out_load            = 1'b1;
                out_word.event_kind = mcfr_pkg::EV_TIMEOUT;
                out_word.light_code = mcfr_pkg::LIGHT_ERROR;
              end
            end else if (light_active_r) begin
              light_remaining_nxt = remaining_dec;
              if (remaining_dec == 16'd0) begin
                light_active_nxt    = 1'b0;
                out_load            = 1'b1;
                out_word.event_kind = mcfr_pkg::EV_LIGHT_IDLE;
                out_word.light_code = mcfr_pkg::LIGHT_IDLE;
              end
            end
          end else if (!collecting_r) begin
            // hunt for sync
            if (in_data.rx_byte == sync_value_r) begin
              collecting_nxt    = 1'b1;
              bytes_taken_nxt   = BT_W'(1);
              frame_elapsed_nxt = '0;
              running_xor_nxt   = '0;
            end
          end else if (bytes_taken_r < BT_W'(FRAME_BYTES - 1)) begin
            // data byte: bytes past the motor set only enter the checksum
            mem_we          = (int'(data_idx) < MOTOR_COUNT);
            running_xor_nxt = running_xor_r ^ in_data.rx_byte;
            bytes_taken_nxt = bytes_taken_r + BT_W'(1);
          end else begin
            // checksum byte closes the frame
            collecting_nxt      = 1'b0;
            light_active_nxt    = 1'b1;
            light_remaining_nxt = light_hold_r;
            if (in_data.rx_byte != running_xor_r) begin
              out_load            = 1'b1;
              out_word.event_kind = mcfr_pkg::EV_BAD_SUM;
              out_word.light_code = mcfr_pkg::LIGHT_ERROR;
            end else begin
              motor_idx_nxt = '0;
              state_nxt     = ST_READ;
            end
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load               = 1'b1;
          out_word.event_kind    = mcfr_pkg::EV_MOTOR;
          out_word.motor_number  = 3'(motor_idx_r);
          out_word.forward_level = lvl_fwd;
          out_word.reverse_level = lvl_rev;
          out_word.light_code    = mcfr_pkg::LIGHT_GOOD;
          out_word.last_of_run   = last_motor;
          if (last_motor) begin
            state_nxt = ST_IDLE;
          end else begin
            motor_idx_nxt = motor_idx_r + MI_W'(1);
            state_nxt     = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_IDLE;
      collecting_r      <= 1'b0;
      bytes_taken_r     <= '0;
      frame_elapsed_r   <= '0;
      running_xor_r     <= '0;
      light_active_r    <= 1'b0;
      light_remaining_r <= '0;
      motor_idx_r       <= '0;
    end else begin
      state_r           <= state_nxt;
      collecting_r      <= collecting_nxt;
      bytes_taken_r     <= bytes_taken_nxt;
      frame_elapsed_r   <= frame_elapsed_nxt;
      running_xor_r     <= running_xor_nxt;
      light_active_r    <= light_active_nxt;
      light_remaining_r <= light_remaining_nxt;
      motor_idx_r       <= motor_idx_nxt;
    end
  end

  // motor store: written by data bytes, read one motor at a time
  always_ff @(posedge clk) begin
    if (mem_we) begin
      motor_mem[MI_W'(data_idx)] <= in_data.rx_byte;
    end
    if (state_r == ST_READ) begin
      // read motors that no data byte reaches as zero
      motor_rd_r <= (int'(motor_idx_r) < FRAME_BYTES - 2) ? motor_mem[motor_idx_r] : 8'd0;
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_seq_not_collecting: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !collecting_r)
    else $error("motor sequencer running while a frame is collected");

  a_read_then_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_READ) |=> (state_r == ST_EMIT))
    else $error("store read not followed by emit");

  a_last_motor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.event_kind == mcfr_pkg::EV_MOTOR) &&
     out_data_r.last_of_run) |-> (out_data_r.motor_number == 3'(MOTOR_COUNT - 1)))
    else $error("run ended before the last motor");

  a_event_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.event_kind != mcfr_pkg::EV_MOTOR)) |->
    (out_data_r.last_of_run && (out_data_r.forward_level == 8'd0) &&
     (out_data_r.reverse_level == 9'd0)))
    else $error("error or light result carries motor levels");

  a_one_direction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.forward_level == 8'd0) ||
                     (out_data_r.reverse_level == 9'd0)))
    else $error("both directions driven");
`endif

endmodule
